// File: hdl/dhtt_pkg.sv
// shared types, constants and helpers of the double hash transposition table
package dhtt_pkg;

  localparam int TABLE_SLOTS = 1024;              // power of two
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int FILL_W      = SLOT_W + 1;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int PIECE_W = 8;
  localparam int DEPTH_W = 7;
  localparam int MOVE_W  = 8;
  localparam int SCORE_W = 32;
  localparam int OUT_W   = 3;
  localparam int ENT_W   = 11;

  localparam int NIB_BITS = 4;
  localparam int NIB_N    = KEY_W / NIB_BITS;
  localparam int NIB_W    = $clog2(NIB_N);
  localparam int RES_W    = 4;                     // holds a residue mod 11
  localparam int RANK_W   = 10;

  localparam logic [RES_W-1:0]  STEP_BASE   = RES_W'(11);
  localparam logic [7:0]        MOD_DIV     = 8'd11;
  localparam logic [14:0]       MOD_RECIP   = 15'd93;   // ~ 1024 / 11
  localparam logic [RANK_W-1:0] QUIET_BONUS = RANK_W'(10);

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [OUT_W-1:0] OUT_INSERTED = 3'd0;
  localparam logic [OUT_W-1:0] OUT_UPDATED  = 3'd1;
  localparam logic [OUT_W-1:0] OUT_KEPT     = 3'd2;
  localparam logic [OUT_W-1:0] OUT_REPLACED = 3'd3;
  localparam logic [OUT_W-1:0] OUT_NO_SLOT  = 3'd4;
  localparam logic [OUT_W-1:0] OUT_GET_DONE = 3'd5;
  localparam logic [OUT_W-1:0] OUT_CLEARED  = 3'd6;

  typedef enum logic [2:0] {
    DEC_NEXT,
    DEC_INSERT,
    DEC_UPDATE,
    DEC_KEEP,
    DEC_REPLACE,
    DEC_HIT,
    DEC_MISS
  } dec_e;

  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic                 quiet;
    logic [MOVE_W-1:0]    move;
    logic [PIECE_W-1:0]   pieces;
    logic [DEPTH_W-1:0]   depth;
    logic [SCORE_W-1:0]   score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;        // capture a new transaction
    logic mod_step;    // fold one key nibble into the residue
    logic advance;     // move to the next probe slot
    logic finish;      // end of probing: write back and latch result
    logic sweep_wr;    // clear one slot of the sweep
    logic fill_clear;  // zero the fill count
    logic res_plain;   // latch a result with no table data
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            mod_last;
    logic            probe_end;
    logic            sweep_last;
  } stat_t;

  // (16 * r + nibble) mod 11 for values below 176, reciprocal with one correction
  function automatic logic [RES_W-1:0] mod11_fold(input logic [7:0] v);
    logic [14:0] prod;
    logic [7:0]  quo;
    logic [7:0]  rem;
    prod = 15'(v) * MOD_RECIP;
    quo  = 8'(prod[14:10]);
    rem  = v - 8'(quo * MOD_DIV);
    if (rem >= MOD_DIV) begin
      rem = rem - MOD_DIV;
    end
    return rem[RES_W-1:0];
  endfunction

endpackage

// File: hdl/double_hash_transposition_table_core.sv
// top level of the double hash transposition table
//
// usage
// - a transaction is taken at a rising edge with start high and busy low;
//   operation_i selects put (0), get (1) or clear (2), any other code only
//   answers "get done" with no table access
// - each transaction gives exactly one result, shown for one cycle with
//   done_o high; the receiver cannot stall, so it must take it then
// - put and get: dispatch, then key mod 11 (one key nibble per cycle), then a
//   read state and a check state per probed slot, as each probe is a read of
//   the single-port slot memory followed by the decision and an optional
//   write-back, then the result
// - clear sweeps the slot memory one slot a cycle
// - one transaction at a time: busy drops in the cycle after done_o, and
//   only then can the next transaction be taken
// - after reset the same sweep runs once with busy high; no transaction is
//   taken until it is over
// - entries_used_o always shows the current count of fresh inserts
module double_hash_transposition_table_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [dhtt_pkg::OP_W-1:0]           operation_i,
  input  logic [dhtt_pkg::KEY_W-1:0]          key_i,
  input  logic [dhtt_pkg::PIECE_W-1:0]        piece_count_i,
  input  logic [dhtt_pkg::DEPTH_W-1:0]        search_depth_i,
  input  logic [dhtt_pkg::MOVE_W-1:0]         move_choice_i,
  input  logic                                quiet_flag_i,
  input  logic signed [dhtt_pkg::SCORE_W-1:0] score_value_i,
  output logic                                done_o,
  output logic [dhtt_pkg::OUT_W-1:0]          outcome_o,
  output logic                                hit_o,
  output logic [dhtt_pkg::DEPTH_W-1:0]        found_depth_o,
  output logic [dhtt_pkg::PIECE_W-1:0]        found_pieces_o,
  output logic [dhtt_pkg::MOVE_W-1:0]         found_move_o,
  output logic                                found_quiet_o,
  output logic signed [dhtt_pkg::SCORE_W-1:0] found_score_o,
  output logic [dhtt_pkg::ENT_W-1:0]          entries_used_o
);
  import dhtt_pkg::*;

  cmd_t  cmd;   // controller to datapath
  stat_t stat;  // datapath to controller

  // sequencing: init sweep, dispatch, mod, probe loop, clear sweep
  dhtt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // request registers, probe address, slot memory and result register
  dhtt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .piece_count_i  (piece_count_i),
    .search_depth_i (search_depth_i),
    .move_choice_i  (move_choice_i),
    .quiet_flag_i   (quiet_flag_i),
    .score_value_i  (score_value_i),
    .outcome_o      (outcome_o),
    .hit_o          (hit_o),
    .found_depth_o  (found_depth_o),
    .found_pieces_o (found_pieces_o),
    .found_move_o   (found_move_o),
    .found_quiet_o  (found_quiet_o),
    .found_score_o  (found_score_o),
    .entries_used_o (entries_used_o)
  );

  // a taken transaction raises busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a transaction");

  // the result shows while the transaction is still open
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a transaction");

  // the result strobe is never held: done_o falls after each result
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // only a get can hit
  a_hit_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (outcome_o == OUT_GET_DONE))
    else $error("hit reported for a non-get result");

  // found fields are zero unless a get hit
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (found_depth_o == '0 && found_pieces_o == '0 &&
                            found_move_o == '0 && !found_quiet_o &&
                            found_score_o == '0))
    else $error("found fields not cleared on a result without hit");

endmodule

// File: hdl/dhtt_ram.sv
// generic single-port ram with registered read
module dhtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dhtt_dp.sv
// datapath: request registers, mod 11 unit, probe address, slot memory, result
module dhtt_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dhtt_pkg::cmd_t                  cmd_i,
  output dhtt_pkg::stat_t                 stat_o,
  input  logic [dhtt_pkg::OP_W-1:0]       operation_i,
  input  logic [dhtt_pkg::KEY_W-1:0]      key_i,
  input  logic [dhtt_pkg::PIECE_W-1:0]    piece_count_i,
  input  logic [dhtt_pkg::DEPTH_W-1:0]    search_depth_i,
  input  logic [dhtt_pkg::MOVE_W-1:0]     move_choice_i,
  input  logic                            quiet_flag_i,
  input  logic signed [dhtt_pkg::SCORE_W-1:0] score_value_i,
  output logic [dhtt_pkg::OUT_W-1:0]      outcome_o,
  output logic                            hit_o,
  output logic [dhtt_pkg::DEPTH_W-1:0]    found_depth_o,
  output logic [dhtt_pkg::PIECE_W-1:0]    found_pieces_o,
  output logic [dhtt_pkg::MOVE_W-1:0]     found_move_o,
  output logic                            found_quiet_o,
  output logic signed [dhtt_pkg::SCORE_W-1:0] found_score_o,
  output logic [dhtt_pkg::ENT_W-1:0]      entries_used_o
);
  import dhtt_pkg::*;

  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [PIECE_W-1:0] pieces_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [MOVE_W-1:0]  move_q;
  logic               quiet_q;
  logic [SCORE_W-1:0] score_q;

  logic [RES_W-1:0]   res_q, res_d;
  logic [NIB_W-1:0]   nib_q;
  logic [SLOT_W-1:0]  idx_q, pcnt_q, sweep_q;
  logic [FILL_W-1:0]  fill_q;

  logic [OUT_W-1:0]   outcome_q;
  logic               hit_q;
  logic [DEPTH_W-1:0] fdepth_q;
  logic [PIECE_W-1:0] fpieces_q;
  logic [MOVE_W-1:0]  fmove_q;
  logic               fquiet_q;
  logic [SCORE_W-1:0] fscore_q;

  logic [NIB_BITS-1:0] nib;
  logic [RES_W-1:0]    step;
  logic [ENTRY_W-1:0]  ram_rdata, ram_wdata;
  logic [SLOT_W-1:0]   ram_addr;
  logic                ram_we;
  entry_t              rd, wr;
  logic                match;
  logic [RANK_W-1:0]   rank_new, rank_old;
  dec_e                dec;
  logic                do_write;

  // mod 11 folded in msb first, one nibble a cycle
  assign nib   = key_q[(NIB_N - 1 - int'(nib_q)) * NIB_BITS +: NIB_BITS];
  assign res_d = mod11_fold({res_q, nib});
  assign step  = STEP_BASE - res_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      key_q    <= key_i;
      pieces_q <= piece_count_i;
      depth_q  <= search_depth_i;
      move_q   <= move_choice_i;
      quiet_q  <= quiet_flag_i;
      score_q  <= score_value_i;
    end
  end

  // probe decision on the slot just read
  assign rd       = entry_t'(ram_rdata);
  assign match    = rd.valid && (rd.key == key_q);
  assign rank_new = RANK_W'(pieces_q) + RANK_W'(depth_q);
  assign rank_old = RANK_W'(rd.pieces) + RANK_W'(rd.depth)
                  + (rd.quiet ? QUIET_BONUS : '0) + (quiet_q ? QUIET_BONUS : '0);

  always_comb begin
    dec = DEC_NEXT;
    if (op_q == OP_GET) begin
      if (!rd.valid) begin
        dec = DEC_MISS;
      end else if (match) begin
        dec = DEC_HIT;
      end
    end else begin
      if (match) begin
        dec = (rd.depth < depth_q) ? DEC_UPDATE : DEC_KEEP;
      end else if (!rd.valid) begin
        dec = DEC_INSERT;
      end else if (rank_new > rank_old) begin
        dec = DEC_REPLACE;
      end
    end
  end

  always_comb begin
    wr.valid  = 1'b1;
    wr.key    = key_q;
    wr.quiet  = quiet_q;
    wr.move   = move_q;
    wr.pieces = pieces_q;
    wr.depth  = depth_q;
    wr.score  = score_q;
    if (dec == DEC_UPDATE) begin
      wr.quiet  = rd.quiet;
      wr.pieces = rd.pieces;
    end
  end

  assign do_write  = (dec == DEC_INSERT) || (dec == DEC_REPLACE) || (dec == DEC_UPDATE);
  assign ram_we    = cmd_i.sweep_wr || (cmd_i.finish && do_write);
  assign ram_addr  = cmd_i.sweep_wr ? sweep_q : idx_q;
  assign ram_wdata = cmd_i.sweep_wr ? '0 : wr;

  dhtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // counters and addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= '0;
      nib_q   <= '0;
      idx_q   <= '0;
      pcnt_q  <= '0;
      sweep_q <= '0;
      fill_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        res_q  <= '0;
        nib_q  <= '0;
        idx_q  <= key_i[SLOT_W-1:0];
        pcnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        res_q <= res_d;
        nib_q <= nib_q + 1'b1;
      end else if (cmd_i.advance) begin
        idx_q  <= idx_q + SLOT_W'(step);
        pcnt_q <= pcnt_q + 1'b1;
      end
      if (cmd_i.sweep_wr) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.fill_clear) begin
        fill_q <= '0;
      end else if (cmd_i.finish && (dec == DEC_INSERT)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_plain || cmd_i.finish) begin
      hit_q     <= 1'b0;
      fdepth_q  <= '0;
      fpieces_q <= '0;
      fmove_q   <= '0;
      fquiet_q  <= 1'b0;
      fscore_q  <= '0;
      if (cmd_i.res_plain) begin
        outcome_q <= (op_q == OP_CLEAR) ? OUT_CLEARED : OUT_GET_DONE;
      end else begin
        case (dec)
          DEC_INSERT:  outcome_q <= OUT_INSERTED;
          DEC_UPDATE:  outcome_q <= OUT_UPDATED;
          DEC_KEEP:    outcome_q <= OUT_KEPT;
          DEC_REPLACE: outcome_q <= OUT_REPLACED;
          DEC_HIT: begin
            outcome_q <= OUT_GET_DONE;
            hit_q     <= 1'b1;
            fdepth_q  <= rd.depth;
            fpieces_q <= rd.pieces;
            fmove_q   <= rd.move;
            fquiet_q  <= rd.quiet;
            fscore_q  <= rd.score;
          end
          DEC_MISS:    outcome_q <= OUT_GET_DONE;
          default:     outcome_q <= (op_q == OP_PUT) ? OUT_NO_SLOT : OUT_GET_DONE;
        endcase
      end
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.mod_last   = (nib_q == NIB_W'(NIB_N - 1));
  assign stat_o.probe_end  = (dec != DEC_NEXT) || (pcnt_q == '1);
  assign stat_o.sweep_last = (sweep_q == '1);

  assign outcome_o      = outcome_q;
  assign hit_o          = hit_q;
  assign found_depth_o  = fdepth_q;
  assign found_pieces_o = fpieces_q;
  assign found_move_o   = fmove_q;
  assign found_quiet_o  = fquiet_q;
  assign found_score_o  = fscore_q;
  assign entries_used_o = ENT_W'(fill_q);

endmodule

// File: hdl/dhtt_ctrl.sv
// controller state machine of the transposition table
module dhtt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  dhtt_pkg::stat_t stat_i,
  output dhtt_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            done_o
);
  import dhtt_pkg::*;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DISP  = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_WIPE  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op) inside
          OP_PUT, OP_GET: state_d = S_MOD;
          OP_CLEAR: begin
            cmd_o.fill_clear = 1'b1;
            state_d          = S_WIPE;
          end
          default: begin
            cmd_o.res_plain = 1'b1;
            state_d         = S_DONE;
          end
        endcase
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.probe_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      S_WIPE: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.res_plain = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule
